>>> hdl/mcpa_pkg.sv
// ----------------------------------------------------------------------------
// MQTT control packet acknowledger: shared definitions
// Packet type codes, status codes, the acknowledgement descriptor passed from
// the parser to the serialiser, and the table of acknowledgement bytes.
// ----------------------------------------------------------------------------
package mcpa_pkg;

  // Longest variable byte integer accepted, in bytes.
  localparam int unsigned MAX_LENGTH_BYTES = 4;

  // Control packet types (upper nibble of the fixed header).
  localparam logic [3:0] PKT_CONNECT     = 4'd1;
  localparam logic [3:0] PKT_CONNACK     = 4'd2;
  localparam logic [3:0] PKT_PUBLISH     = 4'd3;
  localparam logic [3:0] PKT_PUBACK      = 4'd4;
  localparam logic [3:0] PKT_PUBREC      = 4'd5;
  localparam logic [3:0] PKT_PUBREL      = 4'd6;
  localparam logic [3:0] PKT_PUBCOMP     = 4'd7;
  localparam logic [3:0] PKT_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] PKT_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] PKT_PINGREQ     = 4'd12;
  localparam logic [3:0] PKT_PINGRESP    = 4'd13;
  localparam logic [3:0] PKT_DISCONNECT  = 4'd14;

  // Status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_LENGTH      = 3'd1;
  localparam logic [2:0] ST_TRUNCATED   = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_DISCONNECT  = 3'd4;

  // Everything needed to play out the response to one packet.
  typedef struct packed {
    logic        has;      // response carries ack bytes
    logic [2:0]  count;    // number of beats, 1 to 6
    logic [3:0]  kind;     // type of the received packet
    logic [2:0]  status;
    logic [15:0] ident;    // identifier shown on every beat
    logic [1:0]  qos;      // granted QoS for SUBACK
    logic [1:0]  pub_qos;  // QoS of a received PUBLISH
  } ack_desc_t;

  // Byte number idx of the acknowledgement for a packet of the given kind.
  function automatic logic [7:0] ack_byte(input logic [3:0]  kind,
                                          input logic [1:0]  pub_qos,
                                          input logic [15:0] ident,
                                          input logic [1:0]  qos,
                                          input logic [2:0]  idx);
    logic [7:0] head;
    logic [7:0] len;
    logic [7:0] tail;
    logic [7:0] res;
    head = 8'h00;
    len  = 8'h02;
    tail = 8'h00;
    case (kind)
      PKT_CONNECT: begin
        head = {PKT_CONNACK, 4'h0};
        len  = 8'h03;
      end
      PKT_PUBLISH: begin
        head = (pub_qos == 2'd1) ? {PKT_PUBACK, 4'h0} : {PKT_PUBREC, 4'h0};
      end
      PKT_PUBREC:      head = {PKT_PUBREL, 4'h2};
      PKT_PUBREL:      head = {PKT_PUBCOMP, 4'h0};
      PKT_SUBSCRIBE: begin
        head = 8'h90;
        len  = 8'h04;
        tail = {6'd0, qos};
      end
      PKT_UNSUBSCRIBE: begin
        head = 8'hB0;
        len  = 8'h03;
      end
      PKT_PINGREQ: begin
        head = {PKT_PINGRESP, 4'h0};
        len  = 8'h00;
      end
      default:         head = 8'h00;
    endcase
    case (idx)
      3'd0:    res = head;
      3'd1:    res = len;
      3'd2:    res = (kind == PKT_CONNECT) ? 8'h00 : ident[15:8];
      3'd3:    res = (kind == PKT_CONNECT) ? 8'h00 : ident[7:0];
      3'd5:    res = tail;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/mcpa_parser.sv
// ----------------------------------------------------------------------------
// MQTT control packet acknowledger: packet parser
// Walks the packet one byte per beat and, on the last byte, registers a
// descriptor of the response for the serialiser.
// ----------------------------------------------------------------------------
module mcpa_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                desc_valid,
  output mcpa_pkg::ack_desc_t desc,
  input  logic                desc_take
);

  localparam logic [2:0] PH_HDR    = 3'd0;
  localparam logic [2:0] PH_RLEN   = 3'd1;
  localparam logic [2:0] PH_IDENT  = 3'd2;
  localparam logic [2:0] PH_PLEN   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_TOPLEN = 3'd5;
  localparam logic [2:0] PH_OPTS   = 3'd6;
  localparam logic [2:0] PH_DRAIN  = 3'd7;

  logic [2:0]  parse_phase, parse_phase_next;
  logic [3:0]  type_nibble, type_nibble_next;
  logic [3:0]  flag_nibble, flag_nibble_next;
  logic [27:0] length_accum, length_accum_next;
  logic [2:0]  length_byte_count, length_byte_count_next;
  logic [27:0] body_count, body_count_next;
  logic [27:0] field_length, field_length_next;
  logic [15:0] ident_reg, ident_reg_next;
  logic [1:0]  granted_qos, granted_qos_next;
  logic [2:0]  error_code, error_code_next;

  logic        accept;
  logic        topic_done;
  logic [4:0]  shamt;
  logic [27:0] varint_part;
  logic [1:0]  pub_qos;
  mcpa_pkg::ack_desc_t desc_next;

  assign in_ready = !desc_valid || desc_take;
  assign accept   = in_valid && in_ready;

  assign shamt       = 5'(length_byte_count[1:0]) * 5'd7;
  assign varint_part = 28'(data_byte[6:0]) << shamt;

  always_comb begin
    parse_phase_next       = parse_phase;
    type_nibble_next       = type_nibble;
    flag_nibble_next       = flag_nibble;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    body_count_next        = body_count;
    field_length_next      = field_length;
    ident_reg_next         = ident_reg;
    granted_qos_next       = granted_qos;
    error_code_next        = error_code;
    topic_done             = 1'b0;
    if (parse_phase == PH_HDR) begin
      type_nibble_next       = data_byte[7:4];
      flag_nibble_next       = data_byte[3:0];
      length_accum_next      = '0;
      length_byte_count_next = '0;
      body_count_next        = '0;
      field_length_next      = '0;
      ident_reg_next         = '0;
      granted_qos_next       = '0;
      error_code_next        = mcpa_pkg::ST_OK;
      parse_phase_next       = PH_RLEN;
    end else if (parse_phase == PH_RLEN) begin
      length_accum_next      = length_accum | varint_part;
      length_byte_count_next = length_byte_count + 3'd1;
      if (data_byte[7]) begin
        if (length_byte_count_next >= 3'(mcpa_pkg::MAX_LENGTH_BYTES)) begin
          error_code_next  = mcpa_pkg::ST_LENGTH;
          parse_phase_next = PH_DRAIN;
        end
      end else begin
        length_byte_count_next = '0;
        field_length_next      = '0;
        if (type_nibble == mcpa_pkg::PKT_PUBLISH) begin
          parse_phase_next = PH_TOPLEN;
        end else if ((type_nibble >= mcpa_pkg::PKT_PUBACK &&
                      type_nibble <= mcpa_pkg::PKT_SUBSCRIBE) ||
                     type_nibble == mcpa_pkg::PKT_UNSUBSCRIBE) begin
          parse_phase_next = PH_IDENT;
        end else begin
          parse_phase_next = PH_DRAIN;
        end
      end
    end else if (body_count < length_accum) begin
      body_count_next = body_count + 28'd1;
      if (error_code == mcpa_pkg::ST_OK) begin
        case (parse_phase)
          PH_IDENT: begin
            if (length_byte_count == 3'd0) begin
              ident_reg_next         = {data_byte, 8'h00};
              length_byte_count_next = 3'd1;
            end else begin
              ident_reg_next         = ident_reg | 16'(data_byte);
              length_byte_count_next = '0;
              if (type_nibble == mcpa_pkg::PKT_SUBSCRIBE) begin
                parse_phase_next  = PH_PLEN;
                field_length_next = '0;
              end else begin
                parse_phase_next = PH_DRAIN;
              end
            end
          end
          PH_PLEN: begin
            field_length_next      = field_length | varint_part;
            length_byte_count_next = length_byte_count + 3'd1;
            if (data_byte[7]) begin
              if (length_byte_count_next >= 3'(mcpa_pkg::MAX_LENGTH_BYTES)) begin
                error_code_next  = mcpa_pkg::ST_LENGTH;
                parse_phase_next = PH_DRAIN;
              end
            end else if (field_length_next == 28'd0) begin
              parse_phase_next       = PH_TOPLEN;
              length_byte_count_next = '0;
            end else begin
              parse_phase_next = PH_SKIP;
            end
          end
          PH_SKIP: begin
            field_length_next = field_length - 28'd1;
            if (field_length_next == 28'd0) begin
              // The end of a property block leads to the first topic filter.
              if (type_nibble == mcpa_pkg::PKT_SUBSCRIBE && length_byte_count != 3'd0) begin
                parse_phase_next       = PH_TOPLEN;
                length_byte_count_next = '0;
              end else begin
                topic_done = 1'b1;
              end
            end
          end
          PH_TOPLEN: begin
            if (length_byte_count == 3'd0) begin
              field_length_next      = {12'd0, data_byte, 8'h00};
              length_byte_count_next = 3'd1;
            end else begin
              field_length_next      = field_length | 28'(data_byte);
              length_byte_count_next = '0;
              if (field_length_next == 28'd0) begin
                topic_done = 1'b1;
              end else begin
                parse_phase_next = PH_SKIP;
              end
            end
          end
          PH_OPTS: begin
            granted_qos_next       = data_byte[1:0];
            parse_phase_next       = PH_TOPLEN;
            length_byte_count_next = '0;
          end
          default: begin
          end
        endcase
        if (topic_done) begin
          if (type_nibble == mcpa_pkg::PKT_SUBSCRIBE) begin
            parse_phase_next = PH_OPTS;
          end else if (flag_nibble[2:1] != 2'd0) begin
            parse_phase_next       = PH_IDENT;
            length_byte_count_next = '0;
          end else begin
            parse_phase_next = PH_DRAIN;
          end
        end
      end
    end
  end

  // Response descriptor, worked out from the state after this byte.
  assign pub_qos = flag_nibble_next[2:1];

  always_comb begin
    desc_next         = '0;
    desc_next.count   = 3'd1;
    desc_next.kind    = type_nibble_next;
    desc_next.status  = mcpa_pkg::ST_OK;
    desc_next.qos     = granted_qos_next;
    desc_next.pub_qos = pub_qos;
    if (error_code_next != mcpa_pkg::ST_OK) begin
      desc_next.status = mcpa_pkg::ST_LENGTH;
    end else if (parse_phase_next == PH_RLEN || body_count_next < length_accum_next) begin
      desc_next.status = mcpa_pkg::ST_TRUNCATED;
    end else begin
      case (type_nibble_next)
        mcpa_pkg::PKT_CONNECT: begin
          desc_next.has   = 1'b1;
          desc_next.count = 3'd5;
        end
        mcpa_pkg::PKT_PUBLISH: begin
          if (pub_qos == 2'd1 || pub_qos == 2'd2) begin
            desc_next.has   = 1'b1;
            desc_next.count = 3'd4;
            desc_next.ident = ident_reg_next;
          end else if (pub_qos == 2'd3) begin
            desc_next.status = mcpa_pkg::ST_UNSUPPORTED;
          end
        end
        mcpa_pkg::PKT_PUBACK, mcpa_pkg::PKT_PUBCOMP: begin
          desc_next.ident = ident_reg_next;
        end
        mcpa_pkg::PKT_PUBREC, mcpa_pkg::PKT_PUBREL: begin
          desc_next.has   = 1'b1;
          desc_next.count = 3'd4;
          desc_next.ident = ident_reg_next;
        end
        mcpa_pkg::PKT_SUBSCRIBE: begin
          desc_next.has   = 1'b1;
          desc_next.count = 3'd6;
          desc_next.ident = ident_reg_next;
        end
        mcpa_pkg::PKT_UNSUBSCRIBE: begin
          desc_next.has   = 1'b1;
          desc_next.count = 3'd5;
          desc_next.ident = ident_reg_next;
        end
        mcpa_pkg::PKT_PINGREQ: begin
          desc_next.has   = 1'b1;
          desc_next.count = 3'd2;
        end
        mcpa_pkg::PKT_DISCONNECT: desc_next.status = mcpa_pkg::ST_DISCONNECT;
        default:                  desc_next.status = mcpa_pkg::ST_UNSUPPORTED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_HDR;
      desc_valid  <= 1'b0;
    end else begin
      if (accept) begin
        parse_phase <= last_byte ? PH_HDR : parse_phase_next;
      end
      if (accept && last_byte) begin
        desc_valid <= 1'b1;
      end else if (desc_take) begin
        desc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_nibble       <= type_nibble_next;
      flag_nibble       <= flag_nibble_next;
      length_accum      <= length_accum_next;
      length_byte_count <= length_byte_count_next;
      body_count        <= body_count_next;
      field_length      <= field_length_next;
      ident_reg         <= ident_reg_next;
      granted_qos       <= granted_qos_next;
      error_code        <= error_code_next;
    end
    if (accept && last_byte) begin
      desc <= desc_next;
    end
  end

endmodule

>>> hdl/mcpa_serializer.sv
// ----------------------------------------------------------------------------
// MQTT control packet acknowledger: response serialiser
// Holds one response descriptor and plays it out as one beat per ack byte, or as one status beat.
// ----------------------------------------------------------------------------
module mcpa_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc_valid,
  input  mcpa_pkg::ack_desc_t desc,
  output logic                desc_take,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  logic                busy;
  logic [2:0]          idx;
  mcpa_pkg::ack_desc_t cur;
  logic                final_beat;
  logic [7:0]          resp_byte;

  assign final_beat = (idx == cur.count - 3'd1);
  assign desc_take  = desc_valid && (!busy || (m_tready && final_beat));

  assign resp_byte = cur.has ? mcpa_pkg::ack_byte(cur.kind, cur.pub_qos, cur.ident,
                                                  cur.qos, idx) : 8'h00;

  assign m_tvalid = busy;
  assign m_tlast  = final_beat;
  assign m_tuser  = cur.has;
  assign m_tdata  = {1'b0, cur.ident, cur.kind, cur.status, resp_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (desc_take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (final_beat) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_take) begin
      cur <= desc;
    end
  end

endmodule

>>> hdl/mqtt_control_packet_acknowledger.sv
// ----------------------------------------------------------------------------
// MQTT control packet acknowledger
// Parses MQTT v5 control packets byte by byte and returns acknowledgements.
// ----------------------------------------------------------------------------
// The slave side takes one packet byte per beat in s_tdata, with s_tlast on
// the final byte; while s_tready is high, bytes flow in at one beat per
// clock.
// On the s_tlast beat the parser registers a response descriptor. Once idle,
// the serialiser copies it into its own register and drives the first
// response beat from that register.
// A response is one to six beats: one per acknowledgement byte with m_tuser
// high, or a single status beat with m_tuser low; m_tlast marks its last
// beat. The master side plays out one beat per cycle while m_tready is high,
// and back-to-back responses follow with no gap; that bounds throughput.
// When the receiver stalls, the serialiser holds its beat and one further
// response waits in the descriptor register. The slave side keeps taking
// bytes until the next packet ends; s_tready then stays low until the last
// beat of the current response is taken, rising in that same cycle.
// A synchronous reset on rst clears the parser and drops any held response.
// ----------------------------------------------------------------------------
module mqtt_control_packet_acknowledger (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] resp_byte, [10:8] status,
                                 // [14:11] packet_kind, [30:15] packet_ident, [31] zero
  output logic        m_tlast,   // resp_last
  output logic        m_tuser    // has_byte
);

  // Descriptor hand-off between the parser and the serialiser.
  logic                desc_valid;
  logic                desc_take;
  mcpa_pkg::ack_desc_t desc;

  // The parser owns the slave side and keeps all per-packet state.
  mcpa_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .data_byte  (s_tdata),
    .last_byte  (s_tlast),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take)
  );

  // The serialiser owns the master side and steps through the response bytes.
  mcpa_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
